>>> hdl/dmpp_pkg.sv
// Package for the degree-map propagation pass: field widths, register
// indexes and reset values of the configuration registers.
// Depends on nothing; used by the top level and the testbench.
package dmpp_pkg;

  // Field and register widths.
  localparam int unsigned DEG_W       = 16;
  localparam int unsigned LINE_W_W    = 12;
  localparam int unsigned GAIN_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // The 2x2 window sum of four 16-bit values needs two extra bits.
  localparam int unsigned SUM_W       = DEG_W + 2;
  localparam int unsigned PROD_W      = SUM_W + GAIN_W;
  // The increment is the product shifted right by 18 bits.
  localparam int unsigned INC_SHIFT   = 18;

  // Default line capacity.
  localparam int unsigned DMPP_MAX_WIDTH = 2048;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_GAIN       = 2'd1,
    CFG_FLOOR      = 2'd2,
    CFG_CEILING    = 2'd3
  } cfg_idx_t;

  // Reset values: 640 pixels, gain 0.025, floor 0.01, ceiling 1.0.
  localparam logic [LINE_W_W-1:0] LINE_WIDTH_RST = 12'd640;
  localparam logic [GAIN_W-1:0]   GAIN_RST       = 16'd1638;
  localparam logic [DEG_W-1:0]    FLOOR_RST      = 16'd328;
  localparam logic [DEG_W-1:0]    CEILING_RST    = 16'd32768;

endpackage

>>> hdl/dmpp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read and a write to the same address return the old data.
// Depends on nothing.
module dmpp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  // Storage and registered read; read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/degree_map_propagation_pass.sv
// Top level of the degree-map propagation pass.
// Depends on dmpp_pkg and dmpp_ram (the line buffer).
//
// The block takes one pixel per clock and gives one result per clock while
// the output is not stalled. An input beat passes the line-buffer read, the
// window sum, the gain multiply, and the add and clamp into the output
// register, in that order. The line
// buffer is written with the pixel's own value in the same cycle it is read,
// so consecutive pixels never wait on each other, even at a line width of
// one. Each stage holds its own beat, so the input keeps flowing into empty
// stages while a result waits at the output. The line buffer needs no
// clearing pass: its entries count as valid only once the first row of a
// frame has written them. Configuration writes are always accepted and must
// only be made while no pixel is in flight.
module degree_map_propagation_pass #(
  parameter int unsigned MaxWidth = dmpp_pkg::DMPP_MAX_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Pixel input.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dmpp_pkg::DEG_W-1:0]     in_degree_in,
  input  logic                           in_weathered,
  input  logic                           in_start_of_frame,
  input  logic                           in_pass_enable,
  // Result output.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dmpp_pkg::DEG_W-1:0]     out_degree_out,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmpp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW   = $clog2(MaxWidth);
  localparam int unsigned WW   = $clog2(MaxWidth + 1);
  localparam int unsigned CMPW = (WW > dmpp_pkg::LINE_W_W) ? WW : dmpp_pkg::LINE_W_W;

  // Configuration registers.
  logic [dmpp_pkg::LINE_W_W-1:0] line_width_r;
  logic [dmpp_pkg::GAIN_W-1:0]   gain_r;
  logic [dmpp_pkg::DEG_W-1:0]    floor_r;
  logic [dmpp_pkg::DEG_W-1:0]    ceiling_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= dmpp_pkg::LINE_WIDTH_RST;
      gain_r       <= dmpp_pkg::GAIN_RST;
      floor_r      <= dmpp_pkg::FLOOR_RST;
      ceiling_r    <= dmpp_pkg::CEILING_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dmpp_pkg::cfg_idx_t'(cfg_index))
        dmpp_pkg::CFG_LINE_WIDTH: line_width_r <= cfg_data[dmpp_pkg::LINE_W_W-1:0];
        dmpp_pkg::CFG_GAIN:       gain_r       <= cfg_data;
        dmpp_pkg::CFG_FLOOR:      floor_r      <= cfg_data;
        dmpp_pkg::CFG_CEILING:    ceiling_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage handshake: each stage loads when it is empty or its beat moves on.
  logic s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic ld_out, ld3, ld2, ld1;
  logic in_acc, s1_go;

  assign ld_out = !out_valid_r || out_ready;
  assign ld3    = !s3_v_r || ld_out;
  assign ld2    = !s2_v_r || ld3;
  assign ld1    = !s1_v_r || ld2;
  assign in_ready = ld1;
  assign in_acc = in_valid && ld1;
  assign s1_go  = s1_v_r && ld2;

  // Effective line width: zero acts as one, anything above capacity as capacity.
  logic [CMPW-1:0] lw_ext, eff_w;

  always_comb begin
    lw_ext = CMPW'(line_width_r);
    if (lw_ext == '0) begin
      eff_w = CMPW'(1);
    end else if (lw_ext > CMPW'(MaxWidth)) begin
      eff_w = CMPW'(MaxWidth);
    end else begin
      eff_w = lw_ext;
    end
  end

  // Column tracking for the incoming pixel.
  logic [CW-1:0]   col_r, col_nxt, col_sel;
  logic            first_row_r, first_row_nxt;
  logic [CMPW-1:0] c_cur, c_inc;
  logic            fr_cur, upd_sel;

  always_comb begin
    c_cur  = CMPW'(col_r);
    fr_cur = first_row_r;
    if (in_start_of_frame) begin
      c_cur  = '0;
      fr_cur = 1'b1;
    end
    // A width that shrank below the column starts a new row.
    if (c_cur >= eff_w) begin
      c_cur  = '0;
      fr_cur = 1'b0;
    end
    col_sel = c_cur[CW-1:0];
    upd_sel = in_pass_enable && in_weathered && !fr_cur && (c_cur != '0);
    c_inc   = c_cur + CMPW'(1);
    if (c_inc >= eff_w) begin
      col_nxt       = '0;
      first_row_nxt = 1'b0;
    end else begin
      col_nxt       = c_inc[CW-1:0];
      first_row_nxt = fr_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
    end else if (in_acc) begin
      col_r       <= col_nxt;
      first_row_r <= first_row_nxt;
    end
  end

  // Line buffer: read the upper value and store the current one in the same cycle.
  logic [dmpp_pkg::DEG_W-1:0] up_rd;

  dmpp_ram #(
    .Width (dmpp_pkg::DEG_W),
    .Depth (MaxWidth)
  ) u_line (
    .clk     (clk),
    .we      (in_acc),
    .wr_addr (col_sel),
    .wr_data (in_degree_in),
    .re      (in_acc),
    .rd_addr (col_sel),
    .rd_data (up_rd)
  );

  // Stage 1: waits for the line-buffer read.
  logic [dmpp_pkg::DEG_W-1:0] s1_cur_r;
  logic                       s1_upd_r;
  // Window neighbors from the previous pixel.
  logic [dmpp_pkg::DEG_W-1:0] left_r, upl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      left_r <= '0;
      upl_r  <= '0;
    end else begin
      if (ld1) begin
        s1_v_r <= in_acc;
      end
      if (s1_go) begin
        left_r <= s1_cur_r;
        upl_r  <= up_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r <= in_degree_in;
      s1_upd_r <= upd_sel;
    end
  end

  // Stage 2: sum of the 2x2 window.
  logic [dmpp_pkg::SUM_W-1:0] s2_sum_r, sum_nxt;
  logic [dmpp_pkg::DEG_W-1:0] s2_cur_r;
  logic                       s2_upd_r;

  assign sum_nxt = dmpp_pkg::SUM_W'(upl_r) + dmpp_pkg::SUM_W'(up_rd)
                 + dmpp_pkg::SUM_W'(left_r) + dmpp_pkg::SUM_W'(s1_cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ld2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_sum_r <= sum_nxt;
      s2_cur_r <= s1_cur_r;
      s2_upd_r <= s1_upd_r;
    end
  end

  // Stage 3: gain multiply, floored by the shift.
  logic [dmpp_pkg::PROD_W-1:0] prod;
  logic [dmpp_pkg::DEG_W-1:0]  s3_inc_r, s3_cur_r;
  logic                        s3_upd_r;

  assign prod = dmpp_pkg::PROD_W'(s2_sum_r) * dmpp_pkg::PROD_W'(gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (ld3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && ld3) begin
      s3_inc_r <= prod[dmpp_pkg::INC_SHIFT +: dmpp_pkg::DEG_W];
      s3_cur_r <= s2_cur_r;
      s3_upd_r <= s2_upd_r;
    end
  end

  // Output stage: add and clamp; the ceiling test comes first.
  logic [dmpp_pkg::DEG_W:0]   sum_v;
  logic [dmpp_pkg::DEG_W-1:0] res_nxt, out_degree_r;

  always_comb begin
    sum_v = {1'b0, s3_cur_r} + {1'b0, s3_inc_r};
    if (!s3_upd_r) begin
      res_nxt = s3_cur_r;
    end else if (sum_v > {1'b0, ceiling_r}) begin
      res_nxt = ceiling_r;
    end else if (sum_v < {1'b0, floor_r}) begin
      res_nxt = floor_r;
    end else begin
      res_nxt = sum_v[dmpp_pkg::DEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_out) begin
      out_valid_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && ld_out) begin
      out_degree_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_degree_out = out_degree_r;

  // An accepted beat always lands in the line-buffer stage.
  a_acc_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted beat did not reach the read stage");

  // While the read stage is stalled, its line-buffer data must hold.
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !ld2 |=> s1_v_r && $stable(up_rd))
    else $error("line-buffer data changed under a stalled beat");

  // An updated pixel stays inside the clamp range when that range is sane.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && s3_upd_r && (floor_r <= ceiling_r) |->
      (res_nxt <= ceiling_r) && (res_nxt >= floor_r))
    else $error("updated degree outside clamp range");

endmodule

>>> sim/degree_map_propagation_pass_tb.sv
// Testbench for degree_map_propagation_pass: directed window, clamp and width cases,
// then random frames under several register settings, checked beat by beat.
// Depends on dmpp_pkg and the degree_map_propagation_pass RTL.
module degree_map_propagation_pass_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no accepted beat on any channel before the run is abandoned.
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [dmpp_pkg::DEG_W-1:0]      in_degree_in;
  logic                            in_weathered;
  logic                            in_start_of_frame;
  logic                            in_pass_enable;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [dmpp_pkg::DEG_W-1:0]      out_degree_out;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dmpp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dmpp_pkg::CFG_DATA_W-1:0] cfg_data;

  // Shadow copy of the block's registers and pixel history.
  logic [dmpp_pkg::LINE_W_W-1:0]   mdl_width;
  logic [dmpp_pkg::GAIN_W-1:0]     mdl_gain;
  logic [dmpp_pkg::DEG_W-1:0]      mdl_floor;
  logic [dmpp_pkg::DEG_W-1:0]      mdl_ceiling;
  logic [dmpp_pkg::DEG_W-1:0]      row_above [dmpp_pkg::DMPP_MAX_WIDTH];
  logic [dmpp_pkg::DEG_W-1:0]      prev_pixel;
  logic [dmpp_pkg::DEG_W-1:0]      prev_above;
  int unsigned                     next_col;
  bit                              top_row;

  logic [dmpp_pkg::DEG_W-1:0]      expected_degrees [$];
  logic [dmpp_pkg::DEG_W-1:0]      wanted_degree;
  logic [dmpp_pkg::DEG_W-1:0]      predicted_degree;
  int unsigned                     mismatches;
  int unsigned                     results_seen;
  int unsigned                     quiet_cycles;
  int unsigned                     stall_left;
  bit                              idle_on;

  degree_map_propagation_pass u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_degree_in      (in_degree_in),
    .in_weathered      (in_weathered),
    .in_start_of_frame (in_start_of_frame),
    .in_pass_enable    (in_pass_enable),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_degree_out    (out_degree_out),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the updated degree of one pixel and advances the shadow state.
  function automatic logic [dmpp_pkg::DEG_W-1:0] propagate_pixel(
      input logic [dmpp_pkg::DEG_W-1:0] cur,
      input logic wthr,
      input logic sof,
      input logic enable);
    int unsigned                  span;
    int unsigned                  col;
    logic [dmpp_pkg::DEG_W-1:0]   above;
    logic [dmpp_pkg::SUM_W-1:0]   win_sum;
    logic [dmpp_pkg::PROD_W-1:0]  scaled;
    logic [dmpp_pkg::DEG_W:0]     raised;
    logic [dmpp_pkg::DEG_W-1:0]   result;
    // A width of zero behaves as one; anything past the line capacity is capped.
    span = (mdl_width == '0) ? 1 :
           ((32'(mdl_width) > dmpp_pkg::DMPP_MAX_WIDTH) ? dmpp_pkg::DMPP_MAX_WIDTH :
                                                          32'(mdl_width));
    if (sof) begin
      next_col = 0;
      top_row  = 1'b1;
    end
    // A shrunk width can leave the column past the row end: start a new row.
    if (next_col >= span) begin
      next_col = 0;
      top_row  = 1'b0;
    end
    col    = next_col;
    above  = row_above[col];
    result = cur;
    if (enable && wthr && !top_row && col != 0) begin
      win_sum = {2'b00, prev_above} + {2'b00, above} + {2'b00, prev_pixel} + {2'b00, cur};
      scaled  = {{dmpp_pkg::GAIN_W{1'b0}}, win_sum} * {{dmpp_pkg::SUM_W{1'b0}}, mdl_gain};
      raised  = {1'b0, cur} + {1'b0, scaled[dmpp_pkg::PROD_W-1:dmpp_pkg::INC_SHIFT]};
      // The ceiling is tested first, so it wins when the floor lies above it.
      if (raised > {1'b0, mdl_ceiling}) begin
        result = mdl_ceiling;
      end else if (raised < {1'b0, mdl_floor}) begin
        result = mdl_floor;
      end else begin
        result = raised[dmpp_pkg::DEG_W-1:0];
      end
    end
    prev_above     = above;
    prev_pixel     = cur;
    row_above[col] = cur;
    next_col       = col + 1;
    if (next_col >= span) begin
      next_col = 0;
      top_row  = 1'b0;
    end
    return result;
  endfunction

  // Mostly in-range degrees, with the range ends and raw 16-bit codes mixed in.
  function automatic logic [dmpp_pkg::DEG_W-1:0] pick_degree();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // Sends one pixel beat, sometimes after a random gap, and waits for acceptance.
  task automatic send_pixel(input logic [dmpp_pkg::DEG_W-1:0] degree, input logic wthr,
                            input logic sof, input logic enable);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_degree_in      <= degree;
    in_weathered      <= wthr;
    in_start_of_frame <= sof;
    in_pass_enable    <= enable;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Writes one register; valid stays high when another write follows at once.
  task automatic write_reg(input dmpp_pkg::cfg_idx_t idx,
                           input logic [dmpp_pkg::CFG_DATA_W-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) begin
      cfg_valid <= 1'b0;
    end
  endtask

  // Stops the input and lets every pixel in flight come out before going on.
  // The first edge lets the checker log a beat accepted in this time step.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_degrees.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [dmpp_pkg::CFG_DATA_W-1:0] width,
                          input logic [dmpp_pkg::GAIN_W-1:0] gain,
                          input logic [dmpp_pkg::DEG_W-1:0] lo,
                          input logic [dmpp_pkg::DEG_W-1:0] hi);
    wait_idle();
    write_reg(dmpp_pkg::CFG_LINE_WIDTH, width, 1'b0);
    write_reg(dmpp_pkg::CFG_GAIN, gain, 1'b0);
    write_reg(dmpp_pkg::CFG_FLOOR, lo, 1'b0);
    write_reg(dmpp_pkg::CFG_CEILING, hi, 1'b1);
  endtask

  // Random frames: each starts with a start-of-frame pixel, with stray frame
  // starts and flipped enables now and then as noise.
  task automatic run_phase(input int unsigned width, input logic [dmpp_pkg::GAIN_W-1:0] gain,
                           input logic [dmpp_pkg::DEG_W-1:0] lo,
                           input logic [dmpp_pkg::DEG_W-1:0] hi,
                           input int unsigned count, input bit idling);
    logic [3:0]                    junk;
    logic [dmpp_pkg::LINE_W_W-1:0] width_bits;
    int unsigned                   span;
    int unsigned                   sent;
    int unsigned                   frame_len;
    int unsigned                   frame_pos;
    bit                            frame_enable;
    logic                          sof;
    junk       = 4'($urandom_range(0, 15));
    width_bits = 12'(width);
    // Bits above the width field ride along and must be ignored.
    set_regs({junk, width_bits}, gain, lo, hi);
    idle_on    = idling;
    span       = (width == 0) ? 1 :
                 ((width > dmpp_pkg::DMPP_MAX_WIDTH) ? dmpp_pkg::DMPP_MAX_WIDTH : width);
    sent       = 0;
    frame_len  = 0;
    frame_pos  = 0;
    while (sent < count) begin
      if (frame_pos == frame_len) begin
        frame_len    = span * $urandom_range(2, 5) + $urandom_range(0, span - 1);
        frame_pos    = 0;
        frame_enable = ($urandom_range(0, 5) != 0);
      end
      sof = (frame_pos == 0) || ($urandom_range(0, 99) == 0);
      send_pixel(pick_degree(), $urandom_range(0, 9) < 6, sof,
                 ($urandom_range(0, 31) == 0) ? !frame_enable : frame_enable);
      frame_pos++;
      sent++;
    end
  endtask

  // Register reset values: a full 640-pixel first row, then part of the next.
  task automatic test_reset_defaults();
    for (int i = 0; i < 700; i++) begin
      send_pixel(pick_degree(), $urandom_range(0, 9) < 6, i == 0, 1'b1);
    end
  endtask

  // Full gain on a three-wide frame: first column, clamp to ceiling, disabled
  // pass, unweathered pixel, and a raw code above 1.0.
  task automatic test_window_extremes();
    set_regs(16'd3, 16'hFFFF, 16'd0, 16'd32768);
    send_pixel(16'd32768, 1'b1, 1'b1, 1'b1);
    send_pixel(16'hFFFF,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd0,     1'b1, 1'b0, 1'b1);
    send_pixel(16'd1,     1'b1, 1'b0, 1'b1);
    send_pixel(16'd32768, 1'b1, 1'b0, 1'b1);
    send_pixel(16'hFFFF,  1'b1, 1'b0, 1'b0);
    send_pixel(16'd0,     1'b1, 1'b0, 1'b1);
    send_pixel(16'd0,     1'b1, 1'b0, 1'b1);
    send_pixel(16'd100,   1'b0, 1'b0, 1'b1);
  endtask

  // Zero gain with the floor set above the ceiling.
  task automatic test_floor_above_ceiling();
    set_regs(16'd2, 16'd0, 16'd20000, 16'd10000);
    send_pixel(16'd5000,  1'b1, 1'b1, 1'b1);
    send_pixel(16'd5000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd0,     1'b1, 1'b0, 1'b1);
    send_pixel(16'd5000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd0,     1'b1, 1'b0, 1'b1);
    send_pixel(16'd15000, 1'b1, 1'b0, 1'b1);
  endtask

  // A width of zero acts as one, so every pixel sits in the first column.
  task automatic test_width_zero();
    wait_idle();
    write_reg(dmpp_pkg::CFG_LINE_WIDTH, 16'd0, 1'b1);
    send_pixel(16'd1234, 1'b1, 1'b1, 1'b1);
    send_pixel(16'd4321, 1'b1, 1'b0, 1'b1);
  endtask

  // Shrinking the width mid-frame leaves the column past the row end.
  task automatic test_width_shrink();
    set_regs(16'd3, 16'd32768, 16'd0, 16'd32768);
    send_pixel(16'd1000,  1'b1, 1'b1, 1'b1);
    send_pixel(16'd2000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd3000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd4000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd5000,  1'b1, 1'b0, 1'b1);
    wait_idle();
    write_reg(dmpp_pkg::CFG_LINE_WIDTH, 16'hF002, 1'b1);
    send_pixel(16'd6000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd7000,  1'b1, 1'b0, 1'b1);
    send_pixel(16'd8000,  1'b1, 1'b0, 1'b1);
  endtask

  // Random frames under default, extreme and random register settings.
  task automatic test_random_settings();
    int unsigned                 w;
    logic [dmpp_pkg::GAIN_W-1:0] g;
    logic [dmpp_pkg::DEG_W-1:0]  lo;
    logic [dmpp_pkg::DEG_W-1:0]  hi;
    run_phase(5, dmpp_pkg::GAIN_RST, dmpp_pkg::FLOOR_RST, dmpp_pkg::CEILING_RST, 200, 1'b1);
    run_phase(2, 16'hFFFF, 16'd32768, 16'd0, 150, 1'b1);
    repeat (4) begin
      w  = $urandom_range(1, 64);
      g  = 16'($urandom_range(0, 65535));
      lo = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                         16'($urandom_range(0, 16384));
      hi = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                         16'($urandom_range(16384, 32768));
      run_phase(w, g, lo, hi, 100, 1'b1);
    end
  endtask

  // Back-to-back beats with no idling on either side.
  task automatic test_steady_stream();
    run_phase($urandom_range(2, 48), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 8192)), 16'($urandom_range(16384, 32768)), 250, 1'b0);
  endtask

  // Result sink: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 11) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checks each result beat, predicts each pixel beat and tracks register writes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_degrees.size() == 0) begin
          report_mismatch($sformatf("beat %0d: degree_out %0d with nothing expected",
                                    results_seen, out_degree_out));
        end else begin
          wanted_degree = expected_degrees.pop_front();
          if (out_degree_out !== wanted_degree) begin
            report_mismatch($sformatf("beat %0d: degree_out %0d, expected %0d",
                                      results_seen, out_degree_out, wanted_degree));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        predicted_degree = propagate_pixel(in_degree_in, in_weathered,
                                           in_start_of_frame, in_pass_enable);
        expected_degrees = {expected_degrees, predicted_degree};
      end
      if (cfg_valid && cfg_ready) begin
        case (dmpp_pkg::cfg_idx_t'(cfg_index))
          dmpp_pkg::CFG_LINE_WIDTH: mdl_width   = cfg_data[dmpp_pkg::LINE_W_W-1:0];
          dmpp_pkg::CFG_GAIN:       mdl_gain    = cfg_data;
          dmpp_pkg::CFG_FLOOR:      mdl_floor   = cfg_data;
          dmpp_pkg::CFG_CEILING:    mdl_ceiling = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: too long without any accepted beat ends the run.
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready) &&
        !(cfg_valid && cfg_ready)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_degree_in      <= '0;
    in_weathered      <= 1'b0;
    in_start_of_frame <= 1'b0;
    in_pass_enable    <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= dmpp_pkg::CFG_LINE_WIDTH;
    cfg_data          <= '0;
    // Shadow state after reset.
    mdl_width    = dmpp_pkg::LINE_WIDTH_RST;
    mdl_gain     = dmpp_pkg::GAIN_RST;
    mdl_floor    = dmpp_pkg::FLOOR_RST;
    mdl_ceiling  = dmpp_pkg::CEILING_RST;
    for (int k = 0; k < dmpp_pkg::DMPP_MAX_WIDTH; k++) begin
      row_above[k] = '0;
    end
    prev_pixel   = '0;
    prev_above   = '0;
    next_col     = 0;
    top_row      = 1'b1;
    mismatches   = 0;
    results_seen = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    idle_on      = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_window_extremes();
    test_floor_above_ceiling();
    test_width_zero();
    test_width_shrink();
    test_random_settings();
    test_steady_stream();

    wait_idle();
    if (expected_degrees.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_degrees.size()));
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
